// ===== design/xrde_pkg.sv =====
package xrde_pkg;
  localparam int POOL_MAX = 64;
  localparam int UUID_CHARS = 36;
  localparam int MAX_RESULTS = 64;
  localparam int PIDX_W = $clog2(POOL_MAX);

  localparam logic [1:0] KIND_SEED = 2'd0;
  localparam logic [1:0] KIND_RANGE = 2'd1;
  localparam logic [1:0] KIND_UUID = 2'd2;
  localparam logic [1:0] KIND_PICK = 2'd3;

  typedef struct packed {
    logic        start;
    logic [32:0] lo;
    logic [32:0] hi;
  } draw_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } draw_rsp_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    hex_char = (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h57 + {4'd0, d});
  endfunction
endpackage

// ===== design/xrde_draw.sv =====
// Draw unit: advances the generator and scales the draw onto lo..hi with one
// shared 32x33 multiplier, used for the low and then the high half of x.
module xrde_draw import xrde_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_load,
  input  logic [31:0] seed_a,
  input  logic [31:0] seed_b,
  input  draw_req_t   req,
  output draw_rsp_t   rsp
);
  logic [63:0] w1, w2, x;
  logic [32:0] lo, m;
  logic        neg;
  logic [1:0]  phase;
  logic        busy;
  logic [63:0] p1, p2;
  logic [63:0] prod;
  logic [33:0] span;
  logic [63:0] t;
  logic [64:0] mid;
  logic [64:0] top;
  logic [32:0] q;
  logic [32:0] r;

  assign span = {req.hi[32], req.hi} - {req.lo[32], req.lo};
  assign t = w2 ^ w1;
  assign prod = {32'd0, (phase == 2'd0) ? x[31:0] : x[63:32]} * {31'd0, m};
  assign mid = {33'd0, p1[63:32]} + {33'd0, p2[31:0]};
  assign top = {1'b0, p2[63:32]} + {32'd0, mid[64:32]};
  assign q = top[32:0] + {32'd0, mid[31]};
  assign r = lo + (neg ? (33'd0 - q) : q);

  always_ff @(posedge clk) begin
    rsp.done <= 1'b0;
    if (rst) begin
      w1 <= '0;
      w2 <= '0;
      busy <= 1'b0;
      phase <= '0;
    end else if (seed_load) begin
      w1 <= {32'd0, seed_a};
      w2 <= {32'd0, seed_b};
    end else if (req.start) begin
      x <= w1 + w2;
      w1 <= {w1[8:0], w1[63:9]} ^ t ^ (t << 14);
      w2 <= {t[27:0], t[63:28]};
      lo <= req.lo;
      neg <= span[33];
      m <= span[33] ? (33'd0 - span[32:0]) : span[32:0];
      phase <= 2'd0;
      busy <= 1'b1;
    end else if (busy) begin
      unique case (phase)
        2'd0: begin p1 <= prod; phase <= 2'd1; end
        2'd1: begin p2 <= prod; phase <= 2'd2; end
        default: begin
          rsp.value <= r[31:0];
          rsp.done <= 1'b1;
          busy <= 1'b0;
        end
      endcase
    end
  end
endmodule

// ===== design/xoroshiro_random_draw_engine.sv =====
// Channel | Direction | Handshake       | Payload
// in      | input     | valid / stall   | kind, seeds, range, pool_size, count_wanted
// out     | output    | out_valid/out_stall | value, last, error
// Each draw runs in the draw unit and the item is then handed off. A pick fills the
// pool one entry a cycle, then per pick draws and closes the gap one entry a cycle.
// Reset is synchronous. stall refuses new input while a request is in progress or
// a result item waits in the output register.
module xoroshiro_random_draw_engine import xrde_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic [1:0]  kind,
  input  logic [31:0] seed_first,
  input  logic [31:0] seed_second,
  input  logic signed [31:0] range_low,
  input  logic signed [31:0] range_high,
  input  logic [6:0]  pool_size,
  input  logic [6:0]  count_wanted,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] value,
  output logic        last,
  output logic        error
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NEXT = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state;
  logic [1:0] rkind;
  logic [31:0] rlo, rhi;
  logic [6:0] total, done_cnt, psize, remaining;
  logic [5:0] pos;
  logic [PIDX_W-1:0] gap;
  logic [PIDX_W-1:0] pool [POOL_MAX];
  logic [31:0] pend;
  logic pend_last;
  logic seed_load;
  draw_req_t req;
  draw_rsp_t rsp;
  logic [6:0] cnt_sat;
  logic [6:0] pick_idx;
  logic uuid_end;

  assign stall = (state != S_IDLE) || out_valid;
  assign seed_load = valid && !stall && kind == KIND_SEED;
  assign cnt_sat = (count_wanted > 7'(MAX_RESULTS)) ? 7'(MAX_RESULTS) : count_wanted;
  assign pick_idx = (rsp.value[6:0] >= remaining || rsp.value[31:7] != '0)
                    ? remaining - 7'd1 : rsp.value[6:0];
  // The final UUID character is always a drawn digit.
  assign uuid_end = (rkind == KIND_UUID) && (pos == 6'd35);

  xrde_draw u_draw (
    .clk(clk), .rst(rst), .seed_load(seed_load),
    .seed_a(seed_first), .seed_b(seed_second), .req(req), .rsp(rsp)
  );

  always_comb begin
    req.start = (state == S_NEXT) && !out_valid && !(rkind == KIND_UUID &&
                (pos == 6'd8 || pos == 6'd13 || pos == 6'd14 || pos == 6'd18 ||
                 pos == 6'd23));
    req.lo = {rlo[31], rlo};
    req.hi = {rhi[31], rhi};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (valid && !stall) begin
          rkind <= kind;
          done_cnt <= '0;
          pos <= '0;
          rlo <= range_low;
          rhi <= range_high;
          error <= 1'b0;
          unique case (kind)
            KIND_SEED: begin
              value <= '0; last <= 1'b1; out_valid <= 1'b1;
            end
            KIND_RANGE: begin
              total <= cnt_sat;
              if (cnt_sat != '0) state <= S_NEXT;
            end
            KIND_UUID: begin
              total <= 7'(UUID_CHARS);
              rlo <= '0; rhi <= 32'd15;
              state <= S_NEXT;
            end
            default: begin
              total <= count_wanted;
              psize <= pool_size;
              if (count_wanted != '0) begin
                if (pool_size > 7'(POOL_MAX) || count_wanted > pool_size) begin
                  value <= '0; last <= 1'b1; error <= 1'b1; out_valid <= 1'b1;
                end else begin
                  remaining <= '0;
                  state <= S_FILL;
                end
              end
            end
          endcase
        end
        S_FILL: begin
          pool[remaining[PIDX_W-1:0]] <= remaining[PIDX_W-1:0];
          remaining <= remaining + 7'd1;
          if (remaining + 7'd1 == psize) begin
            rlo <= '0;
            rhi <= {25'd0, psize} - 32'd1;
            state <= S_NEXT;
          end
        end
        S_NEXT: if (!out_valid) begin
          if (req.start) state <= S_WAIT;
          else begin
            value <= (pos == 6'd14) ? 32'h34 : 32'h2d;
            last <= 1'b0;
            out_valid <= 1'b1;
            pos <= pos + 6'd1;
            rhi <= (pos == 6'd18) ? 32'd3 : 32'd15;
          end
        end
        S_WAIT: if (rsp.done) begin
          last <= (done_cnt + 7'd1 == total) || uuid_end;
          done_cnt <= done_cnt + 7'd1;
          if (rkind == KIND_PICK) begin
            gap <= pick_idx[PIDX_W-1:0];
            value <= {26'd0, pool[pick_idx[PIDX_W-1:0]]};
            state <= S_SHIFT;
          end else begin
            // The variant digit is one of 8, 9, a, b.
            if (rkind == KIND_UUID)
              value <= (pos == 6'd19)
                       ? {24'd0, (rsp.value[1] ? 8'h61 : 8'h38) + {7'd0, rsp.value[0]}}
                       : {24'd0, hex_char(rsp.value[3:0])};
            else
              value <= rsp.value;
            out_valid <= 1'b1;
            pos <= pos + 6'd1;
            rhi <= (pos == 6'd18) ? 32'd3 : 32'd15;
            if (rkind == KIND_RANGE) rhi <= rhi;
            state <= (done_cnt + 7'd1 == total || uuid_end) ? S_IDLE : S_NEXT;
          end
        end
        S_SHIFT: begin
          if ({1'b0, gap} + 7'd1 < remaining) begin
            pool[gap] <= pool[gap + PIDX_W'(1)];
            gap <= gap + PIDX_W'(1);
          end else begin
            remaining <= remaining - 7'd1;
            rhi <= {25'd0, remaining} - 32'd2;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          out_valid <= 1'b1;
          state <= last ? S_IDLE : S_NEXT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
